>>> rtl/core/mal_pkg.sv
// Shared types and constants for the multiply accumulate long unit.
package mal_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DWORD_W = 2 * WORD_W;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned OP_W = 3;

  // Register number of the program counter; any use of it is unpredictable.
  localparam logic [IDX_W-1:0] PC_INDEX = IDX_W'(15);

  typedef enum logic [OP_W-1:0] {
    OP_MUL   = 3'd0,
    OP_MLA   = 3'd1,
    OP_UMULL = 3'd2,
    OP_UMLAL = 3'd3,
    OP_SMULL = 3'd4,
    OP_SMLAL = 3'd5
  } op_t;

  // Per-instruction control that travels down the pipeline with the data.
  typedef struct packed {
    logic write_en;
    logic is_long;
    logic is_signed;
    logic accum;
    logic flags_req;
  } ctrl_t;

endpackage

>>> rtl/core/mal_decode.sv
// Instruction decoder: operation class and register legality checks.
module mal_decode
  import mal_pkg::*;
(
  input  logic [OP_W-1:0]  op,
  input  logic             set_flags,
  input  logic [IDX_W-1:0] dest_index,
  input  logic [IDX_W-1:0] second_index,
  input  logic [IDX_W-1:0] multiplicand_index,
  input  logic [IDX_W-1:0] multiplier_index,
  output ctrl_t            ctrl
);

  logic uses_pc;
  logic short_ok;
  logic long_ok;

  assign uses_pc = (dest_index == PC_INDEX) || (second_index == PC_INDEX) ||
                   (multiplicand_index == PC_INDEX) || (multiplier_index == PC_INDEX);

  assign short_ok = (dest_index != multiplicand_index);
  assign long_ok  = (dest_index != multiplicand_index) &&
                    (second_index != multiplicand_index) &&
                    (dest_index != second_index);

  always_comb begin
    ctrl           = '0;
    ctrl.flags_req = set_flags;
    unique case (op) inside
      OP_MUL, OP_MLA: begin
        ctrl.write_en = !uses_pc && short_ok;
        ctrl.accum    = (op == OP_MLA);
      end
      OP_UMULL, OP_UMLAL: begin
        ctrl.write_en = !uses_pc && long_ok;
        ctrl.is_long  = 1'b1;
        ctrl.accum    = (op == OP_UMLAL);
      end
      OP_SMULL, OP_SMLAL: begin
        ctrl.write_en  = !uses_pc && long_ok;
        ctrl.is_long   = 1'b1;
        ctrl.is_signed = 1'b1;
        ctrl.accum     = (op == OP_SMLAL);
      end
      default: begin
        ctrl.write_en = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/multiply_accumulate_long_unit.sv
// Top level of the pipelined multiply and multiply-accumulate unit.
//
// This unit executes one multiply instruction per beat: MUL and MLA return a
// 32-bit result, UMULL/UMLAL and SMULL/SMLAL a 64-bit unsigned or signed
// product, with the accumulate forms adding the incoming 64-bit value. It is a
// five-stage pipeline (decode and capture, 32x32 unsigned multiply, signed
// correction of the high half, 64-bit accumulate, flag generation and output
// register), and a new beat can be taken every cycle while the pipeline is not
// held by a result-side stall. Each stage holds its own valid bit and only waits
// when the stage after it is full and blocked, so bubbles collapse and a stall
// on the result side reaches the input only once the pipeline is full. When the
// register choice is unpredictable (any index 15, Rd equal to Rm for the short
// forms, or RdHi, RdLo and Rm not all distinct for the long forms) or the
// operation code is undefined, the result beat carries write_enable low and every
// other field zero. Only N and Z are reported.
module multiply_accumulate_long_unit
  import mal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Instruction channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic               in_set_flags,
  input  logic [WORD_W-1:0]  in_multiplicand,
  input  logic [WORD_W-1:0]  in_multiplier,
  input  logic [WORD_W-1:0]  in_addend_low,
  input  logic [WORD_W-1:0]  in_addend_high,
  input  logic [IDX_W-1:0]   in_dest_index,
  input  logic [IDX_W-1:0]   in_second_index,
  input  logic [IDX_W-1:0]   in_multiplicand_index,
  input  logic [IDX_W-1:0]   in_multiplier_index,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_enable,
  output logic [WORD_W-1:0]  out_result_low,
  output logic [WORD_W-1:0]  out_result_high,
  output logic               out_is_long,
  output logic               out_flags_valid,
  output logic               out_flag_negative,
  output logic               out_flag_zero
);

  // Stage load enables: a stage may load when it is empty or when its
  // contents move on in the same cycle.
  logic en1, en2, en3, en4, en5;

  ctrl_t dec_ctrl;

  // Stage 1: captured operands and decoded control.
  logic               v1_r;
  ctrl_t              ctrl1_r;
  logic [WORD_W-1:0]  a1_r, b1_r;
  logic [DWORD_W-1:0] add1_r, add1_nxt;

  // Stage 2: raw unsigned product and the signed correction term.
  logic               v2_r;
  ctrl_t              ctrl2_r;
  logic [DWORD_W-1:0] prod2_r, prod2_nxt;
  logic [WORD_W-1:0]  corr2_r, corr2_nxt;
  logic [DWORD_W-1:0] add2_r;

  // Stage 3: product with the sign correction applied.
  logic               v3_r;
  ctrl_t              ctrl3_r;
  logic [DWORD_W-1:0] prod3_r, prod3_nxt;
  logic [DWORD_W-1:0] add3_r;

  // Stage 4: accumulated sum.
  logic               v4_r;
  ctrl_t              ctrl4_r;
  logic [DWORD_W-1:0] sum4_r, sum4_nxt;

  // Stage 5: output register.
  logic               v5_r;
  logic               we5_r, we5_nxt;
  logic [WORD_W-1:0]  lo5_r, lo5_nxt;
  logic [WORD_W-1:0]  hi5_r, hi5_nxt;
  logic               long5_r, long5_nxt;
  logic               fv5_r, fv5_nxt;
  logic               neg5_r, neg5_nxt;
  logic               zero5_r, zero5_nxt;

  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall = !en1;

  mal_decode u_decode (
    .op                 (in_op),
    .set_flags          (in_set_flags),
    .dest_index         (in_dest_index),
    .second_index       (in_second_index),
    .multiplicand_index (in_multiplicand_index),
    .multiplier_index   (in_multiplier_index),
    .ctrl               (dec_ctrl)
  );

  // The accumulate value is zero for the plain multiplies; the short form
  // only adds Rn to the low word.
  always_comb begin
    add1_nxt = '0;
    if (dec_ctrl.accum) begin
      add1_nxt[WORD_W-1:0] = in_addend_low;
      if (dec_ctrl.is_long) begin
        add1_nxt[DWORD_W-1:WORD_W] = in_addend_high;
      end
    end
  end

  // A signed product equals the unsigned one minus each operand shifted up
  // by a word whenever the other operand is negative.
  always_comb begin
    prod2_nxt = a1_r * b1_r;
    corr2_nxt = '0;
    if (ctrl1_r.is_signed) begin
      corr2_nxt = (a1_r[WORD_W-1] ? b1_r : '0) + (b1_r[WORD_W-1] ? a1_r : '0);
    end
  end

  assign prod3_nxt = {prod2_r[DWORD_W-1:WORD_W] - corr2_r, prod2_r[WORD_W-1:0]};
  assign sum4_nxt  = prod3_r + add3_r;

  // Result formatting: suppressed writes and unrequested flags read as zero.
  always_comb begin
    we5_nxt   = ctrl4_r.write_en;
    long5_nxt = ctrl4_r.write_en && ctrl4_r.is_long;
    fv5_nxt   = ctrl4_r.write_en && ctrl4_r.flags_req;
    lo5_nxt   = ctrl4_r.write_en ? sum4_r[WORD_W-1:0] : '0;
    hi5_nxt   = long5_nxt ? sum4_r[DWORD_W-1:WORD_W] : '0;
    neg5_nxt  = 1'b0;
    zero5_nxt = 1'b0;
    if (fv5_nxt) begin
      if (ctrl4_r.is_long) begin
        neg5_nxt  = sum4_r[DWORD_W-1];
        zero5_nxt = (sum4_r == '0);
      end else begin
        neg5_nxt  = sum4_r[WORD_W-1];
        zero5_nxt = (sum4_r[WORD_W-1:0] == '0);
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      ctrl1_r <= dec_ctrl;
      a1_r    <= in_multiplicand;
      b1_r    <= in_multiplier;
      add1_r  <= add1_nxt;
    end
    if (en2) begin
      ctrl2_r <= ctrl1_r;
      prod2_r <= prod2_nxt;
      corr2_r <= corr2_nxt;
      add2_r  <= add1_r;
    end
    if (en3) begin
      ctrl3_r <= ctrl2_r;
      prod3_r <= prod3_nxt;
      add3_r  <= add2_r;
    end
    if (en4) begin
      ctrl4_r <= ctrl3_r;
      sum4_r  <= sum4_nxt;
    end
    if (en5) begin
      we5_r   <= we5_nxt;
      lo5_r   <= lo5_nxt;
      hi5_r   <= hi5_nxt;
      long5_r <= long5_nxt;
      fv5_r   <= fv5_nxt;
      neg5_r  <= neg5_nxt;
      zero5_r <= zero5_nxt;
    end
  end

  assign out_valid         = v5_r;
  assign out_write_enable  = we5_r;
  assign out_result_low    = lo5_r;
  assign out_result_high   = hi5_r;
  assign out_is_long       = long5_r;
  assign out_flags_valid   = fv5_r;
  assign out_flag_negative = neg5_r;
  assign out_flag_zero     = zero5_r;

endmodule

>>> rtl/core/mal_checker.sv
// Port-level assertions for the multiply accumulate long unit, with bind.
module mal_checker
  import mal_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_write_enable,
  input logic [WORD_W-1:0] out_result_low,
  input logic [WORD_W-1:0] out_result_high,
  input logic              out_is_long,
  input logic              out_flags_valid,
  input logic              out_flag_negative,
  input logic              out_flag_zero
);

  // A suppressed write carries nothing else.
  a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_result_low == '0 && out_result_high == '0 && !out_is_long &&
      !out_flags_valid && !out_flag_negative && !out_flag_zero)
    else $error("suppressed result beat carries nonzero fields");

  // Short forms leave the high word clear.
  a_short_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_long |-> out_result_high == '0)
    else $error("short result has a nonzero high word");

  // Flags agree with the delivered result.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flags_valid |->
      out_flag_zero == (out_result_low == '0 && out_result_high == '0) &&
      out_flag_negative == (out_is_long ? out_result_high[WORD_W-1]
                                        : out_result_low[WORD_W-1]))
    else $error("N or Z flag disagrees with the result");

  // Unrequested flags read as zero.
  a_flags_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flags_valid |-> !out_flag_negative && !out_flag_zero)
    else $error("flags set without a flag update");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_result_low) && $stable(out_result_high) &&
      $stable(out_write_enable))
    else $error("stalled result beat changed");

endmodule

bind multiply_accumulate_long_unit mal_checker u_mal_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_write_enable  (out_write_enable),
  .out_result_low    (out_result_low),
  .out_result_high   (out_result_high),
  .out_is_long       (out_is_long),
  .out_flags_valid   (out_flags_valid),
  .out_flag_negative (out_flag_negative),
  .out_flag_zero     (out_flag_zero)
);
